/* rtl/expression_max_by_parenthesization_defines.svh */
// ----------------------------------------------------------------------------
// expression max by parenthesization: assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef EXPRESSION_MAX_BY_PARENTHESIZATION_DEFINES_SVH
`define EXPRESSION_MAX_BY_PARENTHESIZATION_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define EMP_ASSERT_SAME(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("port check failed, same cycle");

// antecedent implies consequent in the next cycle
`define EMP_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("port check failed, next cycle");

`endif

/* rtl/emp_pkg.sv */
// ----------------------------------------------------------------------------
// emp_pkg
// shared types and opcodes for the expression max block
// ----------------------------------------------------------------------------
package emp_pkg;

    localparam int VALUE_W = 64;
    localparam int OUT_W   = 52;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;

    typedef logic signed [VALUE_W-1:0] value_t;

    // one table entry: best and worst value of a sub-range
    typedef struct packed {
        value_t hi;
        value_t lo;
    } entry_t;

    typedef struct packed {
        logic       go;
        logic [1:0] op;
    } alu_ctl_t;

endpackage

/* rtl/expression_max_by_parenthesization.sv */
// an item that is not last is taken while idle and busy stays low
// on last, n operands run an interval dp of (n^3-n)/6 splits; each split reads
//   the table, then runs four pairings through the alu (one 32x32 multiplier
//   for multiply); each interval adds a schedule and a write step, each length
//   a schedule step; a final read and the result strobe end it, then the next item is taken
// reset: count, overflow and control clear at once; tables need no clearing pass
// ----------------------------------------------------------------------------
// expression_max_by_parenthesization
// loads digits and operators, then fills min/max tables over all sub-ranges
// and reports the largest value any parenthesization reaches
// ----------------------------------------------------------------------------
module expression_max_by_parenthesization
    import emp_pkg::*;
#(
    parameter int MAX_OPERANDS = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [3:0]              digit,
    input  logic [1:0]              opcode,
    input  logic                    last,
    output logic                    busy,
    output logic                    done,
    output logic signed [OUT_W-1:0] max_value,
    output logic                    too_many
);

    // index of one operand, and counts that must also hold count + 1
    localparam int KW    = (MAX_OPERANDS > 1) ? $clog2(MAX_OPERANDS) : 1;
    localparam int LW    = $clog2(MAX_OPERANDS + 2);
    localparam int DEPTH = MAX_OPERANDS * MAX_OPERANDS;
    localparam int AW    = $clog2(DEPTH);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_SCHED = 9'b000000010,
        S_RD    = 9'b000000100,
        S_LATCH = 9'b000001000,
        S_GO    = 9'b000010000,
        S_WAIT  = 9'b000100000,
        S_WR    = 9'b001000000,
        S_FRD   = 9'b010000000,
        S_FOUT  = 9'b100000000
    } state_t;

    state_t          state_reg, state_next;
    logic [LW-1:0]   cnt_reg, cnt_next;
    logic            ovf_reg, ovf_next;
    logic [LW-1:0]   n_reg, n_next;
    logic [LW-1:0]   len_reg, len_next;
    logic [KW-1:0]   i_reg, i_next;
    logic [KW-1:0]   j_reg, j_next;
    logic [KW-1:0]   k_reg, k_next;
    logic [1:0]      t_reg, t_next;
    value_t          hi_reg, hi_next;
    value_t          lo_reg, lo_next;
    entry_t          a_reg, a_next;
    entry_t          b_reg, b_next;

    // operator after each stored operand
    logic [1:0]      op_store [MAX_OPERANDS];

    logic            store_ok;
    logic [LW:0]     row_end;

    logic            tab_we, tab_re;
    logic [AW-1:0]   tab_waddr, tab_raddr_a, tab_raddr_b;
    entry_t          tab_wdata, tab_rdata_a, tab_rdata_b;

    alu_ctl_t        alu_ctl;
    value_t          alu_a, alu_b, alu_res;
    logic            alu_done;

    function automatic logic [AW-1:0] tab_addr(input logic [KW-1:0] r,
                                               input logic [KW-1:0] c);
        return AW'(r) * AW'(MAX_OPERANDS) + AW'(c);
    endfunction

    assign busy      = (state_reg != S_IDLE);
    assign done      = (state_reg == S_FOUT);
    assign max_value = tab_rdata_a.hi[OUT_W-1:0];
    assign too_many  = ovf_reg;

    assign store_ok  = (cnt_reg < LW'(MAX_OPERANDS));
    assign row_end   = (LW+1)'(i_reg) + (LW+1)'(len_reg);

    // pairing t: bit 1 picks the left min, bit 0 the right min
    assign alu_a     = t_reg[1] ? a_reg.lo : a_reg.hi;
    assign alu_b     = t_reg[0] ? b_reg.lo : b_reg.hi;
    assign alu_ctl.op = op_store[k_reg];
    assign alu_ctl.go = (state_reg == S_GO);

    emp_table #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_table (
        .clk     (clk),
        .we      (tab_we),
        .waddr   (tab_waddr),
        .wdata   (tab_wdata),
        .re      (tab_re),
        .raddr_a (tab_raddr_a),
        .raddr_b (tab_raddr_b),
        .rdata_a (tab_rdata_a),
        .rdata_b (tab_rdata_b)
    );

    emp_alu u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (alu_ctl),
        .a      (alu_a),
        .b      (alu_b),
        .done   (alu_done),
        .result (alu_res)
    );

    // each interval is written only after all of its splits are read, and
    // every read of it comes in a later interval, so no forwarding is needed
    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        ovf_next    = ovf_reg;
        n_next      = n_reg;
        len_next    = len_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        k_next      = k_reg;
        t_next      = t_reg;
        hi_next     = hi_reg;
        lo_next     = lo_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        tab_we      = 1'b0;
        tab_waddr   = tab_addr(i_reg, j_reg);
        tab_wdata   = '{hi: hi_reg, lo: lo_reg};
        tab_re      = 1'b0;
        tab_raddr_a = tab_addr(i_reg, k_reg);
        tab_raddr_b = tab_addr(k_reg + KW'(1), j_reg);

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    // a stored operand is its own single-element interval
                    if (store_ok)
                    begin
                        tab_we    = 1'b1;
                        tab_waddr = tab_addr(cnt_reg[KW-1:0], cnt_reg[KW-1:0]);
                        tab_wdata = '{hi: value_t'(digit), lo: value_t'(digit)};
                        cnt_next  = cnt_reg + LW'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (last)
                    begin
                        n_next     = store_ok ? (cnt_reg + LW'(1)) : cnt_reg;
                        len_next   = LW'(2);
                        i_next     = '0;
                        state_next = S_SCHED;
                    end
                end
            end
            S_SCHED:
            begin
                if (len_reg > n_reg)
                begin
                    state_next = S_FRD;
                end
                else if (row_end > (LW+1)'(n_reg))
                begin
                    len_next = len_reg + LW'(1);
                    i_next   = '0;
                end
                else
                begin
                    j_next     = KW'(row_end - (LW+1)'(1));
                    k_next     = i_reg;
                    hi_next    = {1'b1, {(VALUE_W-1){1'b0}}};
                    lo_next    = {1'b0, {(VALUE_W-1){1'b1}}};
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                tab_re     = 1'b1;
                state_next = S_LATCH;
            end
            S_LATCH:
            begin
                a_next     = tab_rdata_a;
                b_next     = tab_rdata_b;
                t_next     = 2'd0;
                state_next = S_GO;
            end
            S_GO:
            begin
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (alu_done)
                begin
                    if (alu_res > hi_reg)
                    begin
                        hi_next = alu_res;
                    end
                    if (alu_res < lo_reg)
                    begin
                        lo_next = alu_res;
                    end
                    if (t_reg == 2'd3)
                    begin
                        if (k_reg + KW'(1) == j_reg)
                        begin
                            state_next = S_WR;
                        end
                        else
                        begin
                            k_next     = k_reg + KW'(1);
                            state_next = S_RD;
                        end
                    end
                    else
                    begin
                        t_next     = t_reg + 2'd1;
                        state_next = S_GO;
                    end
                end
            end
            S_WR:
            begin
                tab_we     = 1'b1;
                i_next     = i_reg + KW'(1);
                state_next = S_SCHED;
            end
            S_FRD:
            begin
                tab_re      = 1'b1;
                tab_raddr_a = tab_addr('0, KW'(n_reg - LW'(1)));
                state_next  = S_FOUT;
            end
            S_FOUT:
            begin
                // result transfer; load state clears for the next expression
                cnt_next   = '0;
                ovf_next   = 1'b0;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ovf_reg   <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg   <= n_next;
        len_reg <= len_next;
        i_reg   <= i_next;
        j_reg   <= j_next;
        k_reg   <= k_next;
        t_reg   <= t_next;
        hi_reg  <= hi_next;
        lo_reg  <= lo_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        if (state_reg == S_IDLE && start && store_ok)
        begin
            op_store[cnt_reg[KW-1:0]] <= opcode;
        end
    end

endmodule

/* rtl/emp_table.sv */
// ----------------------------------------------------------------------------
// emp_table
// min/max table memory, one write port and two registered read ports
// ----------------------------------------------------------------------------
module emp_table
    import emp_pkg::*;
#(
    parameter int DEPTH = 256,
    parameter int AW    = 8
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  entry_t        wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr_a,
    input  logic [AW-1:0] raddr_b,
    output entry_t        rdata_a,
    output entry_t        rdata_b
);

    entry_t mem [DEPTH];
    entry_t rdata_a_reg;
    entry_t rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a_reg <= mem[raddr_a];
            rdata_b_reg <= mem[raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

/* rtl/emp_alu.sv */
// ----------------------------------------------------------------------------
// emp_alu
// add, subtract or multiply modulo 2^64; multiply uses one 32x32 unit
// over three partial products
// ----------------------------------------------------------------------------
module emp_alu
    import emp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  alu_ctl_t ctl,
    input  value_t   a,
    input  value_t   b,
    output logic     done,
    output value_t   result
);

    logic        busy_reg, busy_next;
    logic        mul_reg, mul_next;
    logic [2:0]  step_reg, step_next;
    value_t      a_reg, a_next;
    value_t      b_reg, b_next;
    logic [63:0] prod_reg, prod_next;
    value_t      acc_reg, acc_next;
    logic [31:0] mul_x, mul_y;

    assign done   = busy_reg && (!mul_reg || step_reg == 3'd4);
    assign result = acc_reg;

    always_comb
    begin
        mul_x = a_reg[31:0];
        mul_y = b_reg[31:0];
        case (step_reg)
            3'd1:    mul_y = b_reg[63:32];
            3'd2:    mul_x = a_reg[63:32];
            default: ;
        endcase
    end

    always_comb
    begin
        busy_next = busy_reg;
        mul_next  = mul_reg;
        step_next = step_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        prod_next = prod_reg;
        acc_next  = acc_reg;
        if (ctl.go)
        begin
            busy_next = 1'b1;
            a_next    = a;
            b_next    = b;
            step_next = 3'd0;
            case (ctl.op)
                OP_MUL:
                begin
                    mul_next = 1'b1;
                    acc_next = '0;
                end
                OP_SUB:
                begin
                    mul_next = 1'b0;
                    acc_next = a - b;
                end
                default:
                begin
                    mul_next = 1'b0;
                    acc_next = a + b;
                end
            endcase
        end
        else if (done)
        begin
            busy_next = 1'b0;
        end
        else if (busy_reg && mul_reg)
        begin
            step_next = step_reg + 3'd1;
            prod_next = {32'd0, mul_x} * {32'd0, mul_y};
            case (step_reg)
                3'd1:    acc_next = acc_reg + value_t'(prod_reg);
                3'd2,
                3'd3:    acc_next = acc_reg + value_t'({prod_reg[31:0], 32'd0});
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            mul_reg  <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            mul_reg  <= mul_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg    <= a_next;
        b_reg    <= b_next;
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

endmodule

/* rtl/emp_checker.sv */
// ----------------------------------------------------------------------------
// emp_checker
// port-level checks of the expression max block, bound to the top level
// ----------------------------------------------------------------------------
`include "expression_max_by_parenthesization_defines.svh"

module emp_checker
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic last,
    input logic busy,
    input logic done
);

    // the result strobe only comes while the block is working
    `EMP_ASSERT_SAME(a_done_busy, clk, rst_n, done, busy)
    // after the result transfer the block is free again
    `EMP_ASSERT_NEXT(a_done_free, clk, rst_n, done, !busy && !done)
    // an operand that is not last is taken and leaves the block free
    `EMP_ASSERT_NEXT(a_load_fast, clk, rst_n, start && !busy && !last, !busy)
    // the last operand starts the table pass
    `EMP_ASSERT_NEXT(a_last_runs, clk, rst_n, start && !busy && last, busy && !done)

endmodule

bind expression_max_by_parenthesization emp_checker u_emp_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .last  (last),
    .busy  (busy),
    .done  (done)
);

/* tb/expression_max_by_parenthesization_tb.sv */
// ----------------------------------------------------------------------------
// expression_max_by_parenthesization_tb
// sends whole expressions digit by digit with random gaps, predicts the best
// parenthesized value with an interval dp of its own, and checks every result
// strobe against the oldest pending prediction
// ----------------------------------------------------------------------------
module expression_max_by_parenthesization_tb;
    import emp_pkg::*;

    localparam int CAPACITY   = 16;
    localparam int ITEM_GOAL  = 850;
    localparam int STALL_MAX  = 100000;   // above the worst full-store dp run

    typedef struct {
        logic [3:0] dig;
        logic [1:0] op;
        logic       lst;
    } term_t;

    typedef struct {
        logic signed [OUT_W-1:0] best;
        logic                    dropped;
    } answer_t;

    logic                    clk;
    logic                    rst_n;
    logic                    start;
    logic [3:0]              digit;
    logic [1:0]              opcode;
    logic                    last;
    logic                    busy;
    logic                    done;
    logic signed [OUT_W-1:0] max_value;
    logic                    too_many;

    term_t   term_q[$];     // terms not yet transferred
    answer_t answer_q[$];   // predicted results not yet seen

    // predictor copy of the load state
    logic [3:0] held_digit[CAPACITY];
    logic [1:0] held_op[CAPACITY];
    int         held_count;
    bit         held_dropped;

    int gap_left;
    int steady_left;        // items left in a stretch with no idling
    int mismatch_count;
    int stall_cycles;

    expression_max_by_parenthesization #(.MAX_OPERANDS(CAPACITY)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .digit     (digit),
        .opcode    (opcode),
        .last      (last),
        .busy      (busy),
        .done      (done),
        .max_value (max_value),
        .too_many  (too_many)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // one operator applied with 64-bit wraparound; code three acts as add
    function automatic longint combine(longint a, longint b, logic [1:0] op);
        case (op)
            OP_MUL:  return a * b;
            OP_SUB:  return a - b;
            default: return a + b;
        endcase
    endfunction

    // interval dp over the held operands, best value of the whole range
    function automatic longint best_value(int n);
        longint hi_t[CAPACITY][CAPACITY];
        longint lo_t[CAPACITY][CAPACITY];
        longint hi, lo, v;
        int j;
        for (int i = 0; i < n; i++)
        begin
            hi_t[i][i] = longint'(held_digit[i]);
            lo_t[i][i] = longint'(held_digit[i]);
        end
        for (int len = 2; len <= n; len++)
        begin
            for (int i = 0; i + len <= n; i++)
            begin
                j  = i + len - 1;
                hi = 64'sh8000_0000_0000_0000;
                lo = 64'sh7fff_ffff_ffff_ffff;
                for (int k = i; k < j; k++)
                begin
                    // the four pairings of the two halves' extremes
                    for (int t = 0; t < 4; t++)
                    begin
                        v = combine(t[1] ? lo_t[i][k] : hi_t[i][k],
                                    t[0] ? lo_t[k+1][j] : hi_t[k+1][j], held_op[k]);
                        if (v > hi) hi = v;
                        if (v < lo) lo = v;
                    end
                end
                hi_t[i][j] = hi;
                lo_t[i][j] = lo;
            end
        end
        return hi_t[0][n-1];
    endfunction

    // update the predictor with one transferred term
    function automatic void take_term(term_t tm);
        answer_t a;
        longint  b;
        if (held_count < CAPACITY)
        begin
            held_digit[held_count] = tm.dig;
            held_op[held_count]    = tm.op;
            held_count++;
        end
        else
            held_dropped = 1'b1;
        if (tm.lst)
        begin
            b         = best_value(held_count);
            a.best    = b[OUT_W-1:0];
            a.dropped = held_dropped;
            answer_q  = {answer_q, a};
            held_count   = 0;
            held_dropped = 1'b0;
        end
    endfunction

    // driver: presents the head of the term queue after a random gap
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start        <= 1'b0;
            digit        <= '0;
            opcode       <= '0;
            last         <= 1'b0;
            gap_left     = $urandom_range(0, 15);
            steady_left  = 0;
            held_count   = 0;
            held_dropped = 1'b0;
        end
        else
        begin
            if (start && !busy)
            begin
                take_term(term_q.pop_front());
                // now and then a stretch of back-to-back transfers
                if (steady_left == 0 && $urandom_range(0, 19) == 0)
                    steady_left = $urandom_range(10, 40);
                if (steady_left > 0)
                begin
                    steady_left--;
                    gap_left = 0;
                end
                else
                    gap_left = $urandom_range(0, 15);
            end
            // a term held off by busy stays on the ports unchanged
            if (!(start && busy))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    start <= 1'b0;
                end
                else if (term_q.size() > 0)
                begin
                    start  <= 1'b1;
                    digit  <= term_q[0].dig;
                    opcode <= term_q[0].op;
                    last   <= term_q[0].lst;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // monitor: each strobe against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (answer_q.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: max_value=%0d too_many=%0b",
                             max_value, too_many);
            end
            else
            begin
                if (max_value !== answer_q[0].best || too_many !== answer_q[0].dropped)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("result mismatch: expected %0d/%0b, got %0d/%0b",
                                 answer_q[0].best, answer_q[0].dropped,
                                 max_value, too_many);
                end
                void'(answer_q.pop_front());
            end
        end
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stall_cycles <= 0;
        else
        begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_MAX)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // queue one expression of n terms
    task automatic add_expression(int n, bit wild);
        term_t tm;
        for (int i = 0; i < n; i++)
        begin
            if (wild && $urandom_range(0, 7) == 0)
                tm.dig = 4'($urandom_range(0, 15));
            else
                tm.dig = 4'($urandom_range(0, 9));
            tm.op  = ($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
            tm.lst = (i == n - 1);
            term_q = {term_q, tm};
        end
    endtask

    task automatic add_term(logic [3:0] d, logic [1:0] op, logic lst);
        term_t tm;
        tm.dig = d;
        tm.op  = op;
        tm.lst = lst;
        term_q = {term_q, tm};
    endtask

    initial
    begin
        int queued;
        int n;
        mismatch_count = 0;
        stall_cycles   = 0;
        rst_n          = 1'b0;

        // single operands at the extremes, digit above nine included
        add_term(4'd0, OP_MUL, 1'b1);
        add_term(4'd9, OP_ADD, 1'b1);
        add_term(4'd15, 2'd3, 1'b1);
        // 1 - 9 * 9: doing the subtraction first wins
        add_term(4'd1, OP_SUB, 1'b0);
        add_term(4'd9, OP_MUL, 1'b0);
        add_term(4'd9, OP_ADD, 1'b1);
        // unused opcode acts as add
        add_term(4'd7, 2'd3, 1'b0);
        add_term(4'd8, OP_SUB, 1'b1);
        // overflow: 17 operands, the last one dropped
        for (int i = 0; i < 17; i++)
            add_term(4'(9 - (i % 10)), 2'(i % 3), i == 16);
        queued = term_q.size();

        // mostly short expressions, a few long and a few over capacity
        while (queued < ITEM_GOAL)
        begin
            case ($urandom_range(0, 19))
                0:       n = CAPACITY;
                1:       n = $urandom_range(CAPACITY + 1, CAPACITY + 3);
                2, 3:    n = $urandom_range(8, CAPACITY - 1);
                default: n = $urandom_range(1, 6);
            endcase
            add_expression(n, 1'b1);
            queued += n;
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (term_q.size() > 0 || start || answer_q.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl
rtl/emp_pkg.sv
rtl/emp_table.sv
rtl/emp_alu.sv
rtl/expression_max_by_parenthesization.sv
rtl/emp_checker.sv
tb/expression_max_by_parenthesization_tb.sv
